### rtl/line_sensor_position_tracker_defines.svh
// Assertion macros used by the checker file.
`ifndef LINE_SENSOR_POSITION_TRACKER_DEFINES_SVH
`define LINE_SENSOR_POSITION_TRACKER_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define LSPT_ASSERT_NOW(lbl, trig, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error("lspt check failed");

// The condition must hold in the cycle after the trigger.
`define LSPT_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error("lspt check failed");

`endif

### rtl/lspt_pkg.sv
package lspt_pkg;

  localparam int SENSOR_COUNT        = 9;
  localparam int SAMPLE_W            = 9;
  localparam int ACTIVE_W            = 4;
  localparam int SUM_W               = 5;
  localparam int MAG_W               = 4;
  localparam int Q_SHIFT             = 8;
  localparam int ERR_W               = 12;
  localparam int STAT_W              = 8;
  localparam int CFG_W               = 8;
  localparam int CFG_IDX_W           = 2;
  localparam int DEFAULT_COUNT_WIDTH = 8;
  localparam int QUEUE_DEPTH         = 2;
  localparam int QPTR_W              = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W              = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_STEPS           = ERR_W;
  localparam int STEP_W              = $clog2(DIV_STEPS);

  localparam logic [3:0] SRC_BIT [SENSOR_COUNT] = '{
    4'd3, 4'd7, 4'd6, 4'd5, 4'd4, 4'd8, 4'd2, 4'd1, 4'd0
  };

  localparam logic signed [SUM_W-1:0] POS_WEIGHT [SENSOR_COUNT] = '{
    -5'sd4, -5'sd3, -5'sd2, -5'sd1, 5'sd0, 5'sd1, 5'sd2, 5'sd3, 5'sd4
  };

  localparam logic              RST_INVERT     = 1'b1;
  localparam logic [ACTIVE_W-1:0] RST_WIDE_THR = 4'd4;
  localparam logic [STAT_W-1:0] RST_LOST_LIMIT = 8'd100;
  localparam logic [STAT_W-1:0] RST_STABLE_CNT = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INVERT     = 2'd0,
    CFG_WIDE_THR   = 2'd1,
    CFG_LOST_LIMIT = 2'd2,
    CFG_STABLE_CNT = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic                invert;
    logic [ACTIVE_W-1:0] wide_thr;
    logic [STAT_W-1:0]   lost_limit;
    logic [STAT_W-1:0]   stable_cnt;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]     line_bits;
    logic [ACTIVE_W-1:0]     count;
    logic signed [SUM_W-1:0] sum;
    logic                    wide;
  } item_t;

endpackage

### rtl/line_sensor_position_tracker.sv
// Channel   | Handshake                | Payload
// ----------+--------------------------+---------------------------------------------
// in        | in_valid_i / in_ready_o  | raw_sample_i
// out       | out_valid_o / out_ready_i| line_bits_o .. wide_stable_o (nine fields)
// cfg       | cfg_we_i (always taken)  | cfg_idx_i, cfg_wdata_i
//
// In the back end a request is loaded, runs through twelve steps of the shared restoring
// divider, then updates the counters and fills the output register when that is free.
// The front end classifies a request in the cycle it arrives and parks it in a two-entry
// queue, so input is taken while the divider runs or the output stalls, until it fills.
// Reset clears the queue, the sequencer, the counters and the held error, and loads
// the register defaults.
module line_sensor_position_tracker #(
  parameter int COUNT_WIDTH = lspt_pkg::DEFAULT_COUNT_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lspt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lspt_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [lspt_pkg::SAMPLE_W-1:0]     raw_sample_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [lspt_pkg::SAMPLE_W-1:0]     line_bits_o,
  output logic [lspt_pkg::ACTIVE_W-1:0]     sensors_active_o,
  output logic signed [lspt_pkg::ERR_W-1:0] position_error_o,
  output logic                              line_seen_o,
  output logic                              line_wide_o,
  output logic signed [lspt_pkg::ERR_W-1:0] held_error_o,
  output logic [lspt_pkg::STAT_W-1:0]       lost_samples_o,
  output logic [lspt_pkg::STAT_W-1:0]       wide_streak_o,
  output logic                              wide_stable_o
);

  lspt_pkg::cfg_t  cfg_q, cfg_d;
  lspt_pkg::item_t f_item, q_item;
  logic            push, full, pop, q_valid;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (lspt_pkg::cfg_idx_e'(cfg_idx_i))
        lspt_pkg::CFG_INVERT:     cfg_d.invert     = cfg_wdata_i[0];
        lspt_pkg::CFG_WIDE_THR:   cfg_d.wide_thr   = cfg_wdata_i[lspt_pkg::ACTIVE_W-1:0];
        lspt_pkg::CFG_LOST_LIMIT: cfg_d.lost_limit = cfg_wdata_i;
        lspt_pkg::CFG_STABLE_CNT: cfg_d.stable_cnt = cfg_wdata_i;
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.invert     <= lspt_pkg::RST_INVERT;
      cfg_q.wide_thr   <= lspt_pkg::RST_WIDE_THR;
      cfg_q.lost_limit <= lspt_pkg::RST_LOST_LIMIT;
      cfg_q.stable_cnt <= lspt_pkg::RST_STABLE_CNT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lspt_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .raw_sample_i (raw_sample_i),
    .cfg_i        (cfg_q),
    .full_i       (full),
    .push_o       (push),
    .item_o       (f_item)
  );

  lspt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  lspt_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .q_valid_i        (q_valid),
    .q_item_i         (q_item),
    .q_pop_o          (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .line_bits_o      (line_bits_o),
    .sensors_active_o (sensors_active_o),
    .position_error_o (position_error_o),
    .line_seen_o      (line_seen_o),
    .line_wide_o      (line_wide_o),
    .held_error_o     (held_error_o),
    .lost_samples_o   (lost_samples_o),
    .wide_streak_o    (wide_streak_o),
    .wide_stable_o    (wide_stable_o)
  );

endmodule

### rtl/lspt_front.sv
module lspt_front (
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [lspt_pkg::SAMPLE_W-1:0]     raw_sample_i,
  input  lspt_pkg::cfg_t                    cfg_i,
  input  logic                              full_i,
  output logic                              push_o,
  output lspt_pkg::item_t                   item_o
);

  logic [lspt_pkg::SAMPLE_W-1:0]     raw;
  logic [lspt_pkg::SAMPLE_W-1:0]     bits;
  logic [lspt_pkg::ACTIVE_W-1:0]     count;
  logic signed [lspt_pkg::SUM_W-1:0] sum;

  always_comb begin
    raw   = cfg_i.invert ? ~raw_sample_i : raw_sample_i;
    bits  = '0;
    count = '0;
    sum   = '0;
    for (int j = 0; j < lspt_pkg::SENSOR_COUNT; j++) begin
      bits[j] = raw[lspt_pkg::SRC_BIT[j]];
      count   = count + lspt_pkg::ACTIVE_W'(bits[j]);
      if (bits[j]) begin
        sum = sum + lspt_pkg::POS_WEIGHT[j];
      end
    end
  end

  assign item_o.line_bits = bits;
  assign item_o.count     = count;
  assign item_o.sum       = sum;
  assign item_o.wide      = (count >= cfg_i.wide_thr);

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

### rtl/lspt_queue.sv
module lspt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lspt_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output lspt_pkg::item_t item_o
);

  lspt_pkg::item_t                  mem_q [lspt_pkg::QUEUE_DEPTH];
  logic [lspt_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [lspt_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [lspt_pkg::QCNT_W-1:0]      cnt_q, cnt_d;
  logic                             do_pop;

  assign full_o  = (cnt_q == lspt_pkg::QCNT_W'(lspt_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + lspt_pkg::QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + lspt_pkg::QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + lspt_pkg::QCNT_W'(1);
    end else if (do_pop && !push_i) begin
      cnt_d = cnt_q - lspt_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### rtl/lspt_back.sv
module lspt_back #(
  parameter int COUNT_WIDTH = lspt_pkg::DEFAULT_COUNT_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lspt_pkg::cfg_t                    cfg_i,
  input  logic                              q_valid_i,
  input  lspt_pkg::item_t                   q_item_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [lspt_pkg::SAMPLE_W-1:0]     line_bits_o,
  output logic [lspt_pkg::ACTIVE_W-1:0]     sensors_active_o,
  output logic signed [lspt_pkg::ERR_W-1:0] position_error_o,
  output logic                              line_seen_o,
  output logic                              line_wide_o,
  output logic signed [lspt_pkg::ERR_W-1:0] held_error_o,
  output logic [lspt_pkg::STAT_W-1:0]       lost_samples_o,
  output logic [lspt_pkg::STAT_W-1:0]       wide_streak_o,
  output logic                              wide_stable_o
);

  localparam int EXT_W = COUNT_WIDTH + lspt_pkg::STAT_W;

  lspt_pkg::back_state_e state_q, state_d;

  lspt_pkg::item_t                   item_q, item_d;
  logic [lspt_pkg::MAG_W-1:0]        rem_q, rem_d;
  logic [lspt_pkg::ERR_W-1:0]        quo_q, quo_d;
  logic [lspt_pkg::STEP_W-1:0]       step_q, step_d;
  logic [COUNT_WIDTH-1:0]            lost_q, lost_d;
  logic [COUNT_WIDTH-1:0]            wide_q, wide_d;
  logic signed [lspt_pkg::ERR_W-1:0] last_err_q, last_err_d;
  logic                              out_valid_q, out_valid_d;
  logic                              load;

  logic [lspt_pkg::SAMPLE_W-1:0]     ob_bits_q;
  logic [lspt_pkg::ACTIVE_W-1:0]     ob_count_q;
  logic signed [lspt_pkg::ERR_W-1:0] ob_err_q, err;
  logic                              ob_seen_q, ob_wide_q, ob_stable_q, stable;

  logic [lspt_pkg::SUM_W-1:0]        neg_sum;
  logic [lspt_pkg::MAG_W-1:0]        mag;
  logic [lspt_pkg::MAG_W:0]          trial;
  logic [EXT_W-1:0]                  lim_ext, hw_max, cap_ext, wide_ext, stab_ext;
  logic [COUNT_WIDTH-1:0]            cap;
  logic                              seen;

  always_comb begin
    neg_sum  = -q_item_i.sum;
    mag      = q_item_i.sum[lspt_pkg::SUM_W-1] ? neg_sum[lspt_pkg::MAG_W-1:0]
                                               : q_item_i.sum[lspt_pkg::MAG_W-1:0];
    trial    = {rem_q, quo_q[lspt_pkg::ERR_W-1]};
    lim_ext  = EXT_W'(cfg_i.lost_limit);
    hw_max   = EXT_W'({COUNT_WIDTH{1'b1}});
    cap_ext  = (lim_ext < hw_max) ? lim_ext : hw_max;
    cap      = cap_ext[COUNT_WIDTH-1:0];
    seen     = (item_q.count != '0);

    if (!seen) begin
      err = '0;
    end else if (item_q.sum[lspt_pkg::SUM_W-1]) begin
      err = -$signed(quo_q);
    end else begin
      err = $signed(quo_q);
    end

    state_d     = state_q;
    item_d      = item_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    step_d      = step_q;
    lost_d      = lost_q;
    wide_d      = wide_q;
    last_err_d  = last_err_q;
    q_pop_o     = 1'b0;
    load        = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      lspt_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          quo_d   = {mag, {lspt_pkg::Q_SHIFT{1'b0}}};
          rem_d   = '0;
          step_d  = '0;
          state_d = lspt_pkg::BK_DIV;
        end
      end
      lspt_pkg::BK_DIV: begin
        if (trial >= {1'b0, item_q.count}) begin
          rem_d = lspt_pkg::MAG_W'(trial - {1'b0, item_q.count});
          quo_d = {quo_q[lspt_pkg::ERR_W-2:0], 1'b1};
        end else begin
          rem_d = trial[lspt_pkg::MAG_W-1:0];
          quo_d = {quo_q[lspt_pkg::ERR_W-2:0], 1'b0};
        end
        step_d = step_q + lspt_pkg::STEP_W'(1);
        if (step_q == lspt_pkg::STEP_W'(lspt_pkg::DIV_STEPS - 1)) begin
          state_d = lspt_pkg::BK_DONE;
        end
      end
      lspt_pkg::BK_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load        = 1'b1;
          out_valid_d = 1'b1;
          state_d     = lspt_pkg::BK_IDLE;
          if (seen) begin
            last_err_d = err;
            lost_d     = '0;
          end else if (lost_q < cap) begin
            lost_d = lost_q + COUNT_WIDTH'(1);
          end
          if (item_q.wide) begin
            if (wide_q < cap) begin
              wide_d = wide_q + COUNT_WIDTH'(1);
            end
          end else begin
            wide_d = '0;
          end
        end
      end
      default: state_d = lspt_pkg::BK_IDLE;
    endcase

    wide_ext = EXT_W'(wide_d);
    stab_ext = EXT_W'(cfg_i.stable_cnt);
    stable   = (cfg_i.stable_cnt == '0) ? item_q.wide : (wide_ext >= stab_ext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lspt_pkg::BK_IDLE;
      step_q      <= '0;
      lost_q      <= '0;
      wide_q      <= '0;
      last_err_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      lost_q      <= lost_d;
      wide_q      <= wide_d;
      last_err_q  <= last_err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    if (load) begin
      ob_bits_q   <= item_q.line_bits;
      ob_count_q  <= item_q.count;
      ob_err_q    <= err;
      ob_seen_q   <= seen;
      ob_wide_q   <= item_q.wide;
      ob_stable_q <= stable;
    end
  end

  logic [EXT_W-1:0] lost_out, wide_out;

  assign lost_out = EXT_W'(lost_q);
  assign wide_out = EXT_W'(wide_q);

  assign out_valid_o      = out_valid_q;
  assign line_bits_o      = ob_bits_q;
  assign sensors_active_o = ob_count_q;
  assign position_error_o = ob_err_q;
  assign line_seen_o      = ob_seen_q;
  assign line_wide_o      = ob_wide_q;
  assign held_error_o     = last_err_q;
  assign lost_samples_o   = lost_out[lspt_pkg::STAT_W-1:0];
  assign wide_streak_o    = wide_out[lspt_pkg::STAT_W-1:0];
  assign wide_stable_o    = ob_stable_q;

endmodule

### rtl/lspt_checker.sv
`include "line_sensor_position_tracker_defines.svh"

module lspt_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [lspt_pkg::SAMPLE_W-1:0]     line_bits_o,
  input logic [lspt_pkg::ACTIVE_W-1:0]     sensors_active_o,
  input logic signed [lspt_pkg::ERR_W-1:0] position_error_o,
  input logic                              line_seen_o,
  input logic                              line_wide_o,
  input logic signed [lspt_pkg::ERR_W-1:0] held_error_o,
  input logic [lspt_pkg::STAT_W-1:0]       lost_samples_o,
  input logic [lspt_pkg::STAT_W-1:0]       wide_streak_o
);

  logic out_stall, count_ok, seen_ok;

  assign out_stall = out_valid_o && !out_ready_i;
  assign count_ok  = ($countones(line_bits_o) == int'(sensors_active_o)) &&
                     (line_seen_o == (sensors_active_o != '0));
  assign seen_ok   = line_seen_o ? (held_error_o == position_error_o && lost_samples_o == '0)
                                 : (position_error_o == '0);

  `LSPT_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable({position_error_o, line_bits_o}))
  `LSPT_ASSERT_NOW(a_count_bits, out_valid_o, count_ok)
  `LSPT_ASSERT_NOW(a_seen_error, out_valid_o, seen_ok)
  `LSPT_ASSERT_NOW(a_wide_streak, out_valid_o && !line_wide_o, wide_streak_o == '0)

endmodule

bind line_sensor_position_tracker lspt_checker u_lspt_checker (.*);
